[src/ep2tm_pkg.sv]
// ----------------------------------------------------------------------------
// ep2tm_pkg
// shared constants and types for the pose to transform core
// ----------------------------------------------------------------------------
package ep2tm_pkg;

    localparam int CordicSteps = 24;
    localparam int CordicUsed  = (CordicSteps > 32) ? 32 : CordicSteps;

    localparam int AngW  = 24;
    localparam int TrW   = 32;
    localparam int CsW   = 34;   // cordic datapath width
    localparam int ZW    = 36;   // reduced angle width

    localparam logic signed [ZW-1:0] Q30Pi     = 36'sd3373259426;
    localparam logic signed [ZW-1:0] Q30TwoPi  = 36'sd6746518852;
    localparam logic signed [ZW-1:0] Q30HalfPi = 36'sd1686629713;
    localparam logic signed [CsW-1:0] Q30Gain  = 34'sd652032874;

    typedef logic signed [CsW-1:0] cs_t;

    typedef struct packed {
        cs_t c;
        cs_t s;
    } cossin_t;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic [31:0] v;
        unique case (i)
            0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
            3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
            9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
            18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
            21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
            24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
            27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return $signed({4'b0000, v});
    endfunction

endpackage

[src/euler_pose_to_transform_matrix_core.sv]
// ----------------------------------------------------------------------------
// euler_pose_to_transform_matrix_core
// pose (translation and y-x-z euler angles) to rigid 3x4 transform
// ----------------------------------------------------------------------------
// throughput: one pose per cycle; the whole pipe advances when the output
//   register is empty or taken, so a stall holds every stage in place
// reset: aresetn clears the stage valid bits only; the data registers are not reset
module euler_pose_to_transform_matrix_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // trans_x[31:0] trans_y[63:32] trans_z[95:64]
    // angle_x[119:96] angle_y[143:120] angle_z[167:144]
    input  logic [167:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // r00 r01 r02 r10 r11 r12 r20 r21 r22 col_x col_y col_z, 32 bits each
    output logic [383:0]  m_tdata
);
    import ep2tm_pkg::*;

    // cordic pipe: 2 reduction stages plus one per step
    localparam int CL = CordicUsed + 2;
    // after cordic: 3 product stages, then output register
    localparam int L  = CL + 4;

    typedef logic signed [63:0] w64_t;
    typedef logic signed [69:0] w70_t;

    logic en;
    logic [L-1:0] v_reg;

    // pipe advances unless the output holds an untaken result
    assign en = !v_reg[L-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = v_reg[L-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[L-2:0], s_tvalid};
        end
    end

    // translation delay line up to the product stages
    logic [95:0] tr_reg [CL];
    always_ff @(posedge aclk) begin
        if (en) begin
            tr_reg[0] <= s_tdata[95:0];
            for (int i = 1; i < CL; i++) tr_reg[i] <= tr_reg[i-1];
        end
    end

    cossin_t csx, csy, csz;
    ep2tm_cordic u_cx (.aclk, .en, .angle(s_tdata[119:96]),  .cs(csx));
    ep2tm_cordic u_cy (.aclk, .en, .angle(s_tdata[143:120]), .cs(csy));
    ep2tm_cordic u_cz (.aclk, .en, .angle(s_tdata[167:144]), .cs(csz));

    // full-width signed product of two cordic-sized operands
    function automatic w70_t mul(input cs_t a, input cs_t b);
        logic signed [2*CsW-1:0] p;
        p = a * b;
        return 70'(p);
    endfunction

    function automatic w64_t rnd(input w70_t v);
        w70_t t;
        t = (v + 70'sd536870912) >>> 30;
        return t[63:0];
    endfunction

    function automatic logic [31:0] sat(input w64_t v);
        if (v > 64'sd2147483647)       return 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648) return 32'h8000_0000;
        else                           return v[31:0];
    endfunction

    // stage a: first products
    cs_t  p01_reg, p21_reg;
    w64_t p02_reg, p22_reg, r10_reg, r11_reg;
    cs_t  cy_a_reg, sy_a_reg, cz_a_reg, sz_a_reg, sx_a_reg;
    logic [95:0] tr_a_reg;
    // stage b: products with z terms
    w70_t m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg, m7_reg;
    w64_t p02_b_reg, p22_b_reg, r10_b_reg, r11_b_reg;
    cs_t  sx_b_reg;
    logic [95:0] tr_b_reg;
    // stage c: sums
    w70_t s0_reg, s1_reg, s6_reg, s7_reg;
    w64_t p02_c_reg, p22_c_reg, r10_c_reg, r11_c_reg;
    cs_t  sx_c_reg;
    logic [95:0] tr_c_reg;
    logic [383:0] out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // rounded y-x products stay within the cordic width
            p01_reg  <= CsW'(rnd(mul(csy.s, csx.s)));
            p02_reg  <= rnd(mul(csy.s, csx.c));
            p21_reg  <= CsW'(rnd(mul(csy.c, csx.s)));
            p22_reg  <= rnd(mul(csy.c, csx.c));
            r10_reg  <= rnd(mul(csx.c, csz.s));
            r11_reg  <= rnd(mul(csx.c, csz.c));
            cy_a_reg <= csy.c;
            sy_a_reg <= csy.s;
            cz_a_reg <= csz.c;
            sz_a_reg <= csz.s;
            sx_a_reg <= csx.s;
            tr_a_reg <= tr_reg[CL-1];

            m0_reg <= mul(cy_a_reg, cz_a_reg);
            m1_reg <= mul(p01_reg, sz_a_reg);
            m2_reg <= mul(p01_reg, cz_a_reg);
            m3_reg <= mul(cy_a_reg, sz_a_reg);
            m4_reg <= mul(p21_reg, sz_a_reg);
            m5_reg <= mul(sy_a_reg, cz_a_reg);
            m6_reg <= mul(sy_a_reg, sz_a_reg);
            m7_reg <= mul(p21_reg, cz_a_reg);
            p02_b_reg <= p02_reg;
            p22_b_reg <= p22_reg;
            r10_b_reg <= r10_reg;
            r11_b_reg <= r11_reg;
            sx_b_reg  <= sx_a_reg;
            tr_b_reg  <= tr_a_reg;

            s0_reg <= m0_reg + m1_reg;
            s1_reg <= m2_reg - m3_reg;
            s6_reg <= m4_reg - m5_reg;
            s7_reg <= m6_reg + m7_reg;
            p02_c_reg <= p02_b_reg;
            p22_c_reg <= p22_b_reg;
            r10_c_reg <= r10_b_reg;
            r11_c_reg <= r11_b_reg;
            sx_c_reg  <= sx_b_reg;
            tr_c_reg  <= tr_b_reg;

            out_reg <= {tr_c_reg,
                        sat(p22_c_reg), sat(rnd(s7_reg)), sat(rnd(s6_reg)),
                        sat(64'(-sx_c_reg)), sat(r11_c_reg), sat(r10_c_reg),
                        sat(p02_c_reg), sat(rnd(s1_reg)), sat(rnd(s0_reg))};
        end
    end

    assign m_tdata = out_reg;

    // a stalled result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // pipe ready whenever output is free
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a transfer in marks the first stage valid
    a_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted item lost");

endmodule

[src/ep2tm_cordic.sv]
// ----------------------------------------------------------------------------
// ep2tm_cordic
// pipelined angle reduction and rotation cordic, one step per stage
// ----------------------------------------------------------------------------
module ep2tm_cordic (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [ep2tm_pkg::AngW-1:0] angle,
    output ep2tm_pkg::cossin_t          cs
);
    import ep2tm_pkg::*;

    localparam int N = CordicUsed;

    // reduction stage 1: scale and bring into (-pi, pi]
    logic signed [ZW-1:0] z1_reg, z1_next;
    always_comb begin
        logic signed [ZW-1:0] a;
        a = ZW'($signed(angle)) <<< 10;
        // |a| < 2*pi*1.28 so at most one correction
        if (a > Q30Pi + Q30TwoPi)       z1_next = a - Q30TwoPi - Q30TwoPi;
        else if (a > Q30Pi)             z1_next = a - Q30TwoPi;
        else if (a <= -Q30Pi - Q30TwoPi) z1_next = a + Q30TwoPi + Q30TwoPi;
        else if (a <= -Q30Pi)           z1_next = a + Q30TwoPi;
        else                            z1_next = a;
    end

    // reduction stage 2: fold into half circle
    logic signed [ZW-1:0] z2_reg, z2_next;
    logic neg2_reg, neg2_next;
    always_comb begin
        if (z1_reg > Q30HalfPi) begin
            z2_next = z1_reg - Q30Pi;
            neg2_next = 1'b1;
        end else if (z1_reg < -Q30HalfPi) begin
            z2_next = z1_reg + Q30Pi;
            neg2_next = 1'b1;
        end else begin
            z2_next = z1_reg;
            neg2_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z1_reg <= z1_next;
            z2_reg <= z2_next;
            neg2_reg <= neg2_next;
        end
    end

    cs_t                  x_reg [1:N];
    cs_t                  y_reg [1:N];
    logic signed [ZW-1:0] z_reg [1:N];
    logic                 n_reg [1:N];

    for (genvar i = 0; i < N; i++) begin : g_step
        cs_t                  x_in, y_in;
        logic signed [ZW-1:0] z_in;
        logic                 n_in;

        if (i == 0) begin : g_head
            assign x_in = Q30Gain;
            assign y_in = '0;
            assign z_in = z2_reg;
            assign n_in = neg2_reg;
        end else begin : g_tail
            assign x_in = x_reg[i];
            assign y_in = y_reg[i];
            assign z_in = z_reg[i];
            assign n_in = n_reg[i];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_in >= 0) begin
                    x_reg[i+1] <= x_in - (y_in >>> i);
                    y_reg[i+1] <= y_in + (x_in >>> i);
                    z_reg[i+1] <= z_in - atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_in + (y_in >>> i);
                    y_reg[i+1] <= y_in - (x_in >>> i);
                    z_reg[i+1] <= z_in + atan_q30(i);
                end
                n_reg[i+1] <= n_in;
            end
        end
    end

    assign cs.c = n_reg[N] ? -x_reg[N] : x_reg[N];
    assign cs.s = n_reg[N] ? -y_reg[N] : y_reg[N];

endmodule

[tb/sv/euler_pose_to_transform_matrix_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_pose_to_transform_matrix_core_test
// streams poses through the core and checks every transform against a
// behavioural cordic and matrix product, with random gaps on both sides
// ----------------------------------------------------------------------------
module euler_pose_to_transform_matrix_core_test;
    import ep2tm_pkg::*;

    localparam int  NumRandom = 500;
    localparam int  MaxGap    = 12;
    localparam longint CycleLimit = 200000;

    localparam longint TwoPi  = 64'sd6746518852;
    localparam longint Pi     = 64'sd3373259426;
    localparam longint HalfPi = 64'sd1686629713;
    localparam longint Gain   = 64'sd652032874;
    localparam longint Half   = 64'sd536870912;

    typedef struct packed {
        logic [23:0] az;
        logic [23:0] ay;
        logic [23:0] ax;
        logic [31:0] tz;
        logic [31:0] ty;
        logic [31:0] tx;
    } pose_t;

    // fields from the lowest bit up: r00 .. r22, col_x, col_y, col_z
    typedef logic [11:0][31:0] xform_t;

    // directed row: pose checked against the predictor
    typedef struct {
        pose_t  pose;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [383:0] m_tdata;

    xform_t   xform_queue[$];
    pose_t    pose_queue[$];
    int       error_count = 0;
    longint   cycle_count = 0;

    euler_pose_to_transform_matrix_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // arithmetic shift, rounding toward minus infinity
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd30(longint v);
        return (v + Half) >>> 30;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic longint atan_entry(int i);
        longint tbl[32] = '{
            'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
            'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
            'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
            'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
            'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
            'h00000001, 'h00000000};
        return tbl[i & 31];
    endfunction

    // angle reduction and rotation-mode cordic
    function automatic void angle_cos_sin(input logic [23:0] raw, output longint c,
                                          output longint s);
        longint z, x, y, dx, dy;
        bit     flip;
        z = longint'($signed(raw)) * 1024;
        z = z % TwoPi;
        if (z < 0) z += TwoPi;
        if (z > Pi) z -= TwoPi;
        flip = 1'b0;
        if (z > HalfPi) begin
            z -= Pi;
            flip = 1'b1;
        end else if (z < -HalfPi) begin
            z += Pi;
            flip = 1'b1;
        end
        x = Gain;
        y = 0;
        for (int i = 0; i < CordicUsed; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_entry(i);
            end else begin
                x += dx; y -= dy; z += atan_entry(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic xform_t pose_transform(pose_t p);
        longint cx, sx, cy, sy, cz, sz, p01, p02, p21, p22;
        xform_t r;
        angle_cos_sin(p.ax, cx, sx);
        angle_cos_sin(p.ay, cy, sy);
        angle_cos_sin(p.az, cz, sz);
        p01 = rnd30(sy * sx);
        p02 = rnd30(sy * cx);
        p21 = rnd30(cy * sx);
        p22 = rnd30(cy * cx);
        r[0]  = clamp32(rnd30(cy * cz + p01 * sz));
        r[1]  = clamp32(rnd30(p01 * cz - cy * sz));
        r[2]  = clamp32(p02);
        r[3]  = clamp32(rnd30(cx * sz));
        r[4]  = clamp32(rnd30(cx * cz));
        r[5]  = clamp32(-sx);
        r[6]  = clamp32(rnd30(p21 * sz - sy * cz));
        r[7]  = clamp32(rnd30(sy * sz + p21 * cz));
        r[8]  = clamp32(p22);
        r[9]  = p.tx;
        r[10] = p.ty;
        r[11] = p.tz;
        return r;
    endfunction

    task automatic report_mismatch(int field, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch at cycle %0d: field %0d got %h want %h",
                 cycle_count, field, got, want);
    endtask

    // random pose: random translations and angles, with angle_x sometimes forced near -1 or the most negative value
    function automatic pose_t random_pose();
        pose_t p;
        p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
        p.ax = 24'($urandom); p.ay = 24'($urandom); p.az = 24'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            p.ax = $urandom_range(0, 1) ? 24'hFFFFFF
                                        : 24'h800000 ^ 24'($urandom_range(0, 15));
        end
        return p;
    endfunction

    // send one pose, waiting out a random gap first
    task automatic send_pose(pose_t p);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MaxGap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // expectations are queued when the transfer is seen on the bus
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) pose_queue.push_back(s_tdata);
    end

    // result side: random stalls, checking against oldest expectation
    initial begin
        int gap;
        xform_t want, got;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MaxGap);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got = m_tdata;
            if (xform_queue.size() == 0) begin
                error_count++;
                $display("unexpected result transfer at cycle %0d", cycle_count);
            end else begin
                want = xform_queue.pop_front();
                for (int f = 0; f < 12; f++) begin
                    if (got[f] !== want[f]) report_mismatch(f, got[f], want[f]);
                end
            end
        end
    end

    // predictor: turns each accepted pose into an expected transform
    always @(posedge aclk) begin
        #1;
        while (pose_queue.size() > 0) xform_queue.push_back(pose_transform(pose_queue.pop_front()));
    end

    // cycle counter and timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        int        settle;
        // cordic gain error makes the exact values not obvious: predictor for all
        row.pose = '{az: 24'h0, ay: 24'h0, ax: 24'h0,
                     tz: 32'h80000000, ty: 32'h7FFFFFFF, tx: 32'h0};
        rows.push_back(row);
        row.pose = '{az: 24'h7FFFFF, ay: 24'h7FFFFF, ax: 24'h7FFFFF,
                     tz: 32'hFFFFFFFF, ty: 32'h0, tx: 32'h7FFFFFFF};
        rows.push_back(row);
        row.pose = '{az: 24'h800000, ay: 24'h800000, ax: 24'h800000,
                     tz: 32'h1, ty: 32'h80000000, tx: 32'hFFFFFFFF};
        rows.push_back(row);
        // near +-pi/2, +-pi and +-2*pi; pi/2 and pi are the folding boundaries
        row.pose = '{az: 24'd1647099, ay: 24'd1647100, ax: 24'd1647098,
                     tz: 32'h12345678, ty: 32'h9ABCDEF0, tx: 32'h0F0F0F0F};
        rows.push_back(row);
        row.pose = '{az: -24'sd1647099, ay: 24'd3294199, ax: -24'sd3294199,
                     tz: 32'hAAAAAAAA, ty: 32'h55555555, tx: 32'hCCCCCCCC};
        rows.push_back(row);
        row.pose = '{az: 24'd6588397, ay: -24'sd6588397, ax: 24'd3294198,
                     tz: 32'h0, ty: 32'h0, tx: 32'h0};
        rows.push_back(row);
        row.pose = '{az: 24'h1, ay: 24'hFFFFFF, ax: 24'h555555,
                     tz: 32'h1, ty: 32'h2, tx: 32'h3};
        rows.push_back(row);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[k]) send_pose(rows[k].pose);
        for (int n = 0; n < NumRandom; n++) send_pose(random_pose());
        s_tvalid <= 1'b0;

        while (xform_queue.size() > 0 || pose_queue.size() > 0) @(posedge aclk);
        settle = CordicUsed + 7 + 4 * MaxGap;
        repeat (settle) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
